### hdl/gda_pkg.sv
`timescale 1ns / 1ps

package gda_pkg;

    localparam int          MAX_DAYS_ADD_DEF = 4095;
    localparam logic [11:0] YEAR_MIN         = 12'd1800;
    localparam logic [11:0] YEAR_MAX         = 12'd2200;
    localparam logic [3:0]  MONTH_FEB        = 4'd2;
    localparam logic [3:0]  MONTH_DEC        = 4'd12;
    localparam logic [2:0]  WD_FRIDAY        = 3'd5;
    localparam logic [2:0]  WD_SATURDAY      = 3'd6;
    localparam logic [2:0]  WD_MONDAY        = 3'd1;
    localparam logic [2:0]  WD_SUNDAY        = 3'd0;

    // Leap rule, exact for century years 1800 through 2300.
    function automatic logic is_leap(input logic [11:0] y);
        logic century;
        century = (y == 12'd1800) || (y == 12'd1900) || (y == 12'd2100) ||
                  (y == 12'd2200) || (y == 12'd2300);
        return (y[1:0] == 2'd0) && !century;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [11:0] y);
        logic [4:0] len;
        case (m)
            4'd2: begin
                len = is_leap(y) ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

    // Days before the first of month m in a common year.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Residue mod 7 by folding octal digits (8 is 1 mod 7).
    function automatic logic [2:0] mod7(input logic [11:0] v);
        logic [4:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[11:9]);
        s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
        s3 = s2[2:0] + 3'(s2[3]);
        return (s3 == 3'd7) ? 3'd0 : s3;
    endfunction

endpackage

### hdl/gregorian_date_arithmetic.sv
`timescale 1ns / 1ps

// Channel  Dir  tdata bits  Fields, lowest bit first
// s_       in   40          in_day[4:0] in_month[8:5] in_year[20:9] days_to_add[32:21]
// m_       out  64          date_ok weekday year_day year_week sum_day sum_month sum_year
//                           sum_ok work_day work_month work_year (bits 61:0)
//
// One beat takes one month stepper step per month boundary crossed, plus a final
// step, while adding days_to_add and again while stepping to the next workday.
// The month stepper does one month length compare and subtract per cycle. An
// invalid date goes straight from S_IDLE to S_OUT.
// Reset is synchronous on aresetn and clears the sequencer and m_tvalid.
// s_tready is high while the sequencer is idle; a result waits in the output
// register for m_tready without blocking the next input beat.

module gregorian_date_arithmetic
    import gda_pkg::*;
#(
    parameter int MAX_DAYS_ADD = MAX_DAYS_ADD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // in_day, in_month, in_year, days_to_add
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // date_ok, weekday, year_day, year_week, sum_day,
                                   // sum_month, sum_year, sum_ok, work_day, work_month,
                                   // work_year
);

    localparam int RW = $clog2(MAX_DAYS_ADD + 1);
    localparam int CW = (RW > 5) ? RW : 5;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_JAN, S_WEEK, S_WEEK2, S_SUM, S_WORK, S_OUT
    } state_t;

    state_t         state_reg, state_next;
    logic [4:0]     d_in_reg, d_in_next;
    logic [3:0]     m_in_reg, m_in_next;
    logic [11:0]    y_in_reg, y_in_next;
    logic [CW-1:0]  nsat_reg, nsat_next;
    logic [8:0]     yd_reg, yd_next;
    logic [8:0]     r400_reg, r400_next;
    logic [6:0]     r100_reg, r100_next;
    logic [2:0]     jan1_reg, jan1_next;
    logic [2:0]     wd_reg, wd_next;
    logic [16:0]    prod_reg, prod_next;
    logic [5:0]     wk_reg, wk_next;
    logic           ok_reg, ok_next;
    logic [4:0]     cd_reg, cd_next;
    logic [3:0]     cm_reg, cm_next;
    logic [11:0]    cy_reg, cy_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic [4:0]     sd_reg, sd_next;
    logic [3:0]     sm_reg, sm_next;
    logic [11:0]    sy_reg, sy_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [63:0]    m_tdata_reg, m_tdata_next;

    logic [4:0]     in_day;
    logic [3:0]     in_month;
    logic [11:0]    in_year;
    logic [11:0]    days_to_add;
    logic           in_valid;
    logic [16:0]    n_ext;
    logic [16:0]    n_sat;
    logic [11:0]    yy;
    logic [11:0]    r400_full;
    logic [11:0]    jan_sum;
    logic [2:0]     first;
    logic [9:0]     wk_arg;
    logic [4:0]     len;
    logic [4:0]     left;
    logic           fits;
    logic [4:0]     step_d;
    logic [3:0]     step_m;
    logic [11:0]    step_y;
    logic [CW-1:0]  step_rem;
    logic [2:0]     work_step;
    logic           sum_ok;

    assign in_day      = s_tdata[4:0];
    assign in_month    = s_tdata[8:5];
    assign in_year     = s_tdata[20:9];
    assign days_to_add = s_tdata[32:21];

    assign in_valid = (in_year >= YEAR_MIN) && (in_year <= YEAR_MAX) &&
                      (in_month >= 4'd1) && (in_month <= MONTH_DEC) &&
                      (in_day >= 5'd1) && (in_day <= month_len(in_month, in_year));

    assign n_ext = 17'(days_to_add);
    assign n_sat = (n_ext > 17'(MAX_DAYS_ADD)) ? 17'(MAX_DAYS_ADD) : n_ext;

    // Year of the day before 1 January, reduced mod 400 (range 1799..2199).
    assign yy        = y_in_reg - 12'd1;
    assign r400_full = (yy >= 12'd2000) ? yy - 12'd2000 : yy - 12'd1600;

    assign jan_sum = 12'd1 + 12'(5 * yy[1:0]) + 12'(4 * r100_reg) + 12'(6 * r400_reg);

    // Offset of the first Monday after 1 January, one to seven days.
    assign first  = (jan1_reg == WD_SUNDAY) ? 3'd1 : 3'(4'd8 - 4'(jan1_reg));
    assign wk_arg = 10'(yd_reg) + 10'd6 - 10'(first);

    // Month stepper: finish inside the month or jump to the next first day.
    assign len      = month_len(cm_reg, cy_reg);
    assign left     = len - cd_reg;
    assign fits     = rem_reg <= CW'(left);
    assign step_d   = fits ? cd_reg + rem_reg[4:0] : 5'd1;
    assign step_rem = rem_reg - (CW'(left) + CW'(1));
    assign step_m   = fits ? cm_reg : ((cm_reg == MONTH_DEC) ? 4'd1 : cm_reg + 4'd1);
    assign step_y   = (!fits && cm_reg == MONTH_DEC) ? cy_reg + 12'd1 : cy_reg;

    assign work_step = (wd_reg == WD_FRIDAY) ? 3'd3 : (wd_reg == WD_SATURDAY) ? 3'd2 : 3'd1;
    assign sum_ok    = ok_reg && (sy_reg <= YEAR_MAX);

    always_comb begin
        state_next    = state_reg;
        d_in_next     = d_in_reg;
        m_in_next     = m_in_reg;
        y_in_next     = y_in_reg;
        nsat_next     = nsat_reg;
        yd_next       = yd_reg;
        r400_next     = r400_reg;
        r100_next     = r100_reg;
        jan1_next     = jan1_reg;
        wd_next       = wd_reg;
        prod_next     = prod_reg;
        wk_next       = wk_reg;
        ok_next       = ok_reg;
        cd_next       = cd_reg;
        cm_next       = cm_reg;
        cy_next       = cy_reg;
        rem_next      = rem_reg;
        sd_next       = sd_reg;
        sm_next       = sm_reg;
        sy_next       = sy_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    d_in_next = in_day;
                    m_in_next = in_month;
                    y_in_next = in_year;
                    nsat_next = CW'(n_sat);
                    ok_next   = in_valid;
                    if (in_valid) begin
                        state_next = S_PREP;
                    end else begin
                        // Clear every field of an invalid date.
                        wd_next    = '0;
                        yd_next    = '0;
                        wk_next    = '0;
                        sd_next    = '0;
                        sm_next    = '0;
                        sy_next    = '0;
                        cd_next    = '0;
                        cm_next    = '0;
                        cy_next    = '0;
                        state_next = S_OUT;
                    end
                end
            end
            S_PREP: begin
                yd_next   = days_before(m_in_reg) + 9'(d_in_reg) +
                            9'(is_leap(y_in_reg) && (m_in_reg > MONTH_FEB));
                r400_next = r400_full[8:0];
                if (r400_full >= 12'd300) begin
                    r100_next = 7'(r400_full - 12'd300);
                end else if (r400_full >= 12'd200) begin
                    r100_next = 7'(r400_full - 12'd200);
                end else if (r400_full >= 12'd100) begin
                    r100_next = 7'(r400_full - 12'd100);
                end else begin
                    r100_next = r400_full[6:0];
                end
                state_next = S_JAN;
            end
            S_JAN: begin
                jan1_next  = mod7(jan_sum);
                state_next = S_WEEK;
            end
            S_WEEK: begin
                wd_next    = mod7(12'(jan1_reg) + 12'(yd_reg) - 12'd1);
                // Divide by 7 through the reciprocal 293 / 2048.
                prod_next  = 17'(wk_arg[8:0]) * 17'd293;
                state_next = S_WEEK2;
            end
            S_WEEK2: begin
                wk_next    = prod_reg[16:11] + 6'd1;
                cd_next    = d_in_reg;
                cm_next    = m_in_reg;
                cy_next    = y_in_reg;
                rem_next   = nsat_reg;
                state_next = S_SUM;
            end
            S_SUM: begin
                cd_next  = step_d;
                cm_next  = step_m;
                cy_next  = step_y;
                rem_next = step_rem;
                if (fits) begin
                    sd_next    = step_d;
                    sm_next    = step_m;
                    sy_next    = step_y;
                    cd_next    = d_in_reg;
                    cm_next    = m_in_reg;
                    cy_next    = y_in_reg;
                    rem_next   = CW'(work_step);
                    state_next = S_WORK;
                end
            end
            S_WORK: begin
                cd_next  = step_d;
                cm_next  = step_m;
                cy_next  = step_y;
                rem_next = step_rem;
                if (fits) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, cy_reg, cm_reg, cd_reg, sum_ok, sy_reg,
                                     sm_reg, sd_reg, wk_reg, yd_reg, wd_reg, ok_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        d_in_reg    <= d_in_next;
        m_in_reg    <= m_in_next;
        y_in_reg    <= y_in_next;
        nsat_reg    <= nsat_next;
        yd_reg      <= yd_next;
        r400_reg    <= r400_next;
        r100_reg    <= r100_next;
        jan1_reg    <= jan1_next;
        wd_reg      <= wd_next;
        prod_reg    <= prod_next;
        wk_reg      <= wk_next;
        ok_reg      <= ok_next;
        cd_reg      <= cd_next;
        cm_reg      <= cm_next;
        cy_reg      <= cy_next;
        rem_reg     <= rem_next;
        sd_reg      <= sd_next;
        sm_reg      <= sm_next;
        sy_reg      <= sy_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while sequencer busy");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata == 64'd0)
        else $error("invalid date with nonzero result fields");

    a_sum_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[40] == (m_tdata[39:28] <= YEAR_MAX))
        else $error("sum flag disagrees with sum year");

    a_step_day: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUM || state_reg == S_WORK) |-> cd_reg != 5'd0 && cd_reg <= len)
        else $error("stepper day outside its month");

endmodule

### tb/sv/tb_gregorian_date_arithmetic.sv
`timescale 1ns / 1ps

module tb_gregorian_date_arithmetic;
    import gda_pkg::*;

    typedef struct {
        logic        date_ok;
        logic [2:0]  weekday;
        logic [8:0]  year_day;
        logic [5:0]  year_week;
        logic [4:0]  sum_day;
        logic [3:0]  sum_month;
        logic [11:0] sum_year;
        logic        sum_ok;
        logic [4:0]  work_day;
        logic [3:0]  work_month;
        logic [11:0] work_year;
    } date_report_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // in_day, in_month, in_year, days_to_add
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // date_ok, weekday, year_day, year_week, sum_day,
                                  // sum_month, sum_year, sum_ok, work_day, work_month,
                                  // work_year

    date_report_t pending_reports[$];
    bit           steady        = 1'b0;
    int           dates_sent    = 0;
    int           valid_dates   = 0;
    int           late_sums     = 0;
    int           reports_seen  = 0;
    int           mismatches    = 0;

    gregorian_date_arithmetic uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #(5_000_000);
        $display("tb_gregorian_date_arithmetic failed");
        $finish;
    end

    function automatic bit leap_year(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_days(int m, int y);
        if (m == int'(MONTH_FEB)) begin
            return leap_year(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic int days_in_year(int y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic int ordinal_day(int y, int m, int d);
        int o;
        o = d;
        for (int k = 1; k < m; k++) begin
            o += month_days(k, y);
        end
        return o;
    endfunction

    // Day count with 1 January of year 1 as day 1 (a Monday), so mod 7 is the weekday.
    function automatic int serial_day(int y, int o);
        int p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400 + o;
    endfunction

    function automatic void advance_date(input int y, input int o, input int n,
                                         output int ry, output int rm, output int rd);
        int t;
        t  = o + n;
        ry = y;
        while (t > days_in_year(ry)) begin
            t -= days_in_year(ry);
            ry++;
        end
        rm = 1;
        while (t > month_days(rm, ry)) begin
            t -= month_days(rm, ry);
            rm++;
        end
        rd = t;
    endfunction

    function automatic date_report_t predict_report(int d, int m, int y, int n);
        date_report_t r;
        int o, wd, jan1_wd, first_mon, mondays, step;
        int sy, sm, sd, wy, wm, wdd;
        r = '{default: '0};
        if (y < int'(YEAR_MIN) || y > int'(YEAR_MAX) || m < 1 || m > int'(MONTH_DEC) ||
            d < 1 || d > month_days(m, y)) begin
            return r;
        end
        if (n > MAX_DAYS_ADD_DEF) begin
            n = MAX_DAYS_ADD_DEF;
        end
        o         = ordinal_day(y, m, d);
        wd        = serial_day(y, o) % 7;
        jan1_wd   = serial_day(y, 1) % 7;
        first_mon = (int'(WD_MONDAY) - jan1_wd + 7) % 7;
        if (first_mon == 0) begin
            first_mon = 7;
        end
        mondays = (o - 1 >= first_mon) ? (o - 1 - first_mon) / 7 + 1 : 0;
        step = (wd == int'(WD_FRIDAY)) ? 3 : (wd == int'(WD_SATURDAY)) ? 2 : 1;
        advance_date(y, o, n, sy, sm, sd);
        advance_date(y, o, step, wy, wm, wdd);
        r.date_ok    = 1'b1;
        r.weekday    = 3'(wd);
        r.year_day   = 9'(o);
        r.year_week  = 6'(mondays + 1);
        r.sum_day    = 5'(sd);
        r.sum_month  = 4'(sm);
        r.sum_year   = 12'(sy);
        r.sum_ok     = (sy <= int'(YEAR_MAX));
        r.work_day   = 5'(wdd);
        r.work_month = 4'(wm);
        r.work_year  = 12'(wy);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 31);
    end

    always @(posedge aclk) begin
        date_report_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.date_ok    = m_tdata[0];
            got.weekday    = m_tdata[3:1];
            got.year_day   = m_tdata[12:4];
            got.year_week  = m_tdata[18:13];
            got.sum_day    = m_tdata[23:19];
            got.sum_month  = m_tdata[27:24];
            got.sum_year   = m_tdata[39:28];
            got.sum_ok     = m_tdata[40];
            got.work_day   = m_tdata[45:41];
            got.work_month = m_tdata[49:46];
            got.work_year  = m_tdata[61:50];
            reports_seen++;
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected beat, tdata", m_tdata, 0);
            end else begin
                want = pending_reports.pop_front();
                if (got.date_ok !== want.date_ok)
                    report_mismatch("date_ok", got.date_ok, want.date_ok);
                if (got.weekday !== want.weekday)
                    report_mismatch("weekday", got.weekday, want.weekday);
                if (got.year_day !== want.year_day)
                    report_mismatch("year_day", got.year_day, want.year_day);
                if (got.year_week !== want.year_week)
                    report_mismatch("year_week", got.year_week, want.year_week);
                if (got.sum_day !== want.sum_day)
                    report_mismatch("sum_day", got.sum_day, want.sum_day);
                if (got.sum_month !== want.sum_month)
                    report_mismatch("sum_month", got.sum_month, want.sum_month);
                if (got.sum_year !== want.sum_year)
                    report_mismatch("sum_year", got.sum_year, want.sum_year);
                if (got.sum_ok !== want.sum_ok)
                    report_mismatch("sum_ok", got.sum_ok, want.sum_ok);
                if (got.work_day !== want.work_day)
                    report_mismatch("work_day", got.work_day, want.work_day);
                if (got.work_month !== want.work_month)
                    report_mismatch("work_month", got.work_month, want.work_month);
                if (got.work_year !== want.work_year)
                    report_mismatch("work_year", got.work_year, want.work_year);
            end
        end
    end

    task automatic send_date(logic [4:0] d, logic [3:0] m, logic [11:0] y, logic [11:0] n);
        date_report_t want;
        if (!steady) begin
            while ($urandom_range(0, 99) < 31) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tdata  <= {7'd0, n, y, m, d};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        want = predict_report(d, m, y, n);
        pending_reports.push_back(want);
        dates_sent++;
        if (want.date_ok) begin
            valid_dates++;
            if (!want.sum_ok) begin
                late_sums++;
            end
        end
    endtask

    // Hold the input idle until every outstanding result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
    endtask

    task automatic test_calendar_edges();
        send_date(5'd1, 4'd1, 12'd1800, 12'd0);
        send_date(5'd31, 4'd12, 12'd2200, 12'd0);
        send_date(5'd31, 4'd12, 12'd2200, 12'd4095);
        send_date(5'd1, 4'd1, 12'd1800, 12'd4095);
        send_date(5'd29, 4'd2, 12'd2000, 12'd1);
        send_date(5'd29, 4'd2, 12'd1804, 12'd365);
        send_date(5'd28, 4'd2, 12'd1900, 12'd1);
        send_date(5'd31, 4'd1, 12'd2100, 12'd29);
        send_date(5'd1, 4'd1, 12'd2189, 12'd4095);
        send_date(5'd15, 4'd6, 12'd2195, 12'd4095);
        send_date(5'd31, 4'd12, 12'd2012, 12'd0);
    endtask

    task automatic test_invalid_dates();
        send_date(5'd1, 4'd1, 12'd1799, 12'd5);
        send_date(5'd1, 4'd1, 12'd2201, 12'd5);
        send_date(5'd0, 4'd0, 12'd0, 12'd0);
        send_date(5'd31, 4'd15, 12'd4095, 12'd4095);
        send_date(5'd0, 4'd6, 12'd2000, 12'd10);
        send_date(5'd31, 4'd4, 12'd2000, 12'd0);
        send_date(5'd29, 4'd2, 12'd1900, 12'd0);
        send_date(5'd29, 4'd2, 12'd2100, 12'd0);
        send_date(5'd1, 4'd13, 12'd2000, 12'd0);
        send_date(5'd30, 4'd2, 12'd2000, 12'd0);
    endtask

    // One full week at the end of 2199, so each weekday is sent once; only 31 December steps into the new year.
    task automatic test_workday_rules();
        for (int d = 25; d <= 31; d++) begin
            send_date(5'(d), 4'd12, 12'd2199, 12'($urandom_range(0, 4095)));
        end
    endtask

    task automatic send_random_date();
        int          y, m, d;
        logic [11:0] n;
        int          pick;
        pick = $urandom_range(0, 99);
        y    = $urandom_range(int'(YEAR_MIN), int'(YEAR_MAX));
        m    = $urandom_range(1, 12);
        d    = $urandom_range(1, month_days(m, y));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: n = 12'($urandom_range(0, 60));
            4, 5, 6:    n = 12'($urandom_range(0, 1500));
            7:          n = 12'd4095;
            default:    n = 12'($urandom);
        endcase
        if (pick < 8) begin
            send_date(5'($urandom), 4'($urandom), 12'($urandom), 12'($urandom));
        end else if (pick < 15) begin
            d = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(month_days(m, y) + 1, 31);
            if (d == 0 || d > month_days(m, y)) begin
                send_date(5'(d), 4'(m), 12'(y), n);
            end else begin
                send_date(5'd0, 4'(m), 12'(y), n);
            end
        end else begin
            send_date(5'(d), 4'(m), 12'(y), n);
        end
    endtask

    task automatic test_random_dates(int count);
        for (int i = 0; i < count; i++) begin
            send_random_date();
            if (i == count / 2) begin
                drain_results();
            end
        end
    endtask

    task automatic test_steady_stream(int count);
        steady = 1'b1;
        for (int i = 0; i < count; i++) begin
            send_random_date();
        end
        drain_results();
        steady = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_calendar_edges();
        test_invalid_dates();
        test_workday_rules();
        test_random_dates(560);
        test_steady_stream(60);
        drain_results();
        repeat (200) @(posedge aclk);
        $display("Summary: %0d dates sent, %0d valid, %0d with sums beyond 2200",
                 dates_sent, valid_dates, late_sums);
        $display("Summary: %0d result beats compared, %0d mismatches",
                 reports_seen, mismatches);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("tb_gregorian_date_arithmetic passed");
        end else begin
            $display("tb_gregorian_date_arithmetic failed");
        end
        $finish;
    end

endmodule
